>>> rtl/qwrp_pkg.sv
package qwrp_pkg;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_ENTRY = 2'd2
  } status_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] title_handle;
    logic [15:0] singer_handle;
    logic [6:0]  position;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] removed_title;
    logic [15:0] removed_singer;
    logic [6:0]  entry_count;
    logic        is_empty;
    logic        is_full;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    append;
    logic    start_remove;
    logic    shift;
    logic    finish_remove;
    logic    emit;
    status_t code;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_append;
    logic full;
    logic pos_ok;
    logic shift_busy;
    logic out_stall;
  } dp_stat_t;

endpackage

>>> rtl/qwrp_req_if.sv
interface qwrp_req_if;
  logic              valid;
  logic              ready;
  qwrp_pkg::req_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/qwrp_rsp_if.sv
interface qwrp_rsp_if;
  logic              valid;
  logic              ready;
  qwrp_pkg::rsp_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/queue_with_remove_at_position.sv
// Channel    Dir  Payload                                              Handshake
// request    in   cmd, title_handle, singer_handle, position           valid/ready
// response   out  status, removed_title, removed_singer, entry_count,  valid/ready
//                 is_empty, is_full
//
// An append or a refused command goes from acceptance through the decide state
// to the result state. A removal at position p moves each later entry one place
// toward the head, one per cycle, over the store's single read and write port.
// Synchronous reset empties the queue at once; the store itself is not cleared.
// A stalled response holds in its register while the next command is taken;
// that command's result then waits until the register is free.
module queue_with_remove_at_position #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  qwrp_req_if.sink    request,
  qwrp_rsp_if.source  response
);

  qwrp_pkg::ctl_cmd_t ctl_cmd;
  qwrp_pkg::dp_stat_t dp_stat;
  logic               in_ready;

  assign request.ready = in_ready;

  qwrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  qwrp_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (ctl_cmd),
    .stat     (dp_stat),
    .req_data (request.data),
    .rsp      (response)
  );

endmodule

>>> rtl/qwrp_ram.sv
module qwrp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/qwrp_ctrl.sv
module qwrp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  qwrp_pkg::dp_stat_t  stat,
  output qwrp_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT,
    S_RESULT
  } state_t;

  state_t            state, state_next;
  qwrp_pkg::status_t code, code_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next        = state;
    code_next         = code;
    cmd               = '0;
    cmd.code          = code;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_append) begin
          if (stat.full) begin
            code_next = qwrp_pkg::ST_FULL;
          end else begin
            cmd.append = 1'b1;
            code_next  = qwrp_pkg::ST_DONE;
          end
          state_next = S_RESULT;
        end else if (stat.pos_ok) begin
          cmd.start_remove = 1'b1;
          code_next        = qwrp_pkg::ST_DONE;
          state_next       = S_SHIFT;
        end else begin
          code_next  = qwrp_pkg::ST_NO_ENTRY;
          state_next = S_RESULT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_busy) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.finish_remove = 1'b1;
          state_next        = S_RESULT;
        end
      end
      S_RESULT: begin
        // hold until the output register is free
        if (!stat.out_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= qwrp_pkg::ST_DONE;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule

>>> rtl/qwrp_dpath.sv
module qwrp_dpath #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  qwrp_pkg::ctl_cmd_t  cmd,
  output qwrp_pkg::dp_stat_t  stat,
  input  qwrp_pkg::req_t      req_data,
  qwrp_rsp_if.source          rsp
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int XW = (CW > 7) ? CW : 7;

  logic [CW-1:0]   count;
  logic [CW-1:0]   rp;
  logic [CW-1:0]   rp_m1;
  logic [AW-1:0]   wr_addr;
  logic            wr_pend;
  logic            cap_pend;
  qwrp_pkg::req_t  cur;
  logic [15:0]     got_title;
  logic [15:0]     got_singer;
  qwrp_pkg::rsp_t  out_q;
  logic            out_valid;

  logic [XW-1:0]   pos_x;
  logic [XW-1:0]   pos_m1_x;
  logic [XW-1:0]   count_x;
  logic            rp_more;
  logic            full;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [31:0]     ram_rdata;

  assign pos_x    = XW'(cur.position);
  assign pos_m1_x = pos_x - XW'(1);
  assign count_x  = XW'(count);
  assign rp_m1    = rp - CW'(1);
  assign rp_more  = (rp < count);
  assign full     = (count == CW'(QUEUE_DEPTH));

  assign stat.is_append  = (cur.cmd == qwrp_pkg::CMD_APPEND);
  assign stat.full       = full;
  assign stat.pos_ok     = (pos_x != '0) && (pos_x <= count_x);
  assign stat.shift_busy = cap_pend | wr_pend | rp_more;
  assign stat.out_stall  = out_valid & ~rsp.ready;

  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd.append) begin
      ram_we    = 1'b1;
      ram_waddr = count[AW-1:0];
      ram_wdata = {cur.title_handle, cur.singer_handle};
    end
    if (cmd.start_remove) begin
      ram_re    = 1'b1;
      ram_raddr = pos_m1_x[AW-1:0];
    end
    if (cmd.shift) begin
      // move the entry read last cycle one place toward the head
      if (wr_pend) begin
        ram_we    = 1'b1;
        ram_waddr = wr_addr;
        ram_wdata = ram_rdata;
      end
      if (rp_more) begin
        ram_re    = 1'b1;
        ram_raddr = rp[AW-1:0];
      end
    end
  end

  qwrp_ram #(
    .WIDTH (32),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      wr_pend   <= 1'b0;
      cap_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.append) begin
        count <= count + CW'(1);
      end
      if (cmd.finish_remove) begin
        count <= count - CW'(1);
      end
      if (cmd.start_remove) begin
        cap_pend <= 1'b1;
        wr_pend  <= 1'b0;
      end
      if (cmd.shift) begin
        cap_pend <= 1'b0;
        wr_pend  <= rp_more;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur        <= req_data;
      got_title  <= '0;
      got_singer <= '0;
    end
    if (cmd.start_remove) begin
      rp <= pos_x[CW-1:0];
    end
    if (cmd.shift) begin
      if (cap_pend) begin
        got_title  <= ram_rdata[31:16];
        got_singer <= ram_rdata[15:0];
      end
      if (rp_more) begin
        wr_addr <= rp_m1[AW-1:0];
        rp      <= rp + CW'(1);
      end
    end
    if (cmd.emit) begin
      out_q.status         <= cmd.code;
      out_q.removed_title  <= got_title;
      out_q.removed_singer <= got_singer;
      out_q.entry_count    <= count_x[6:0];
      out_q.is_empty       <= (count == '0);
      out_q.is_full        <= full;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> !full)
    else $error("append issued on a full queue");

  a_remove_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.finish_remove |-> (count != '0))
    else $error("removal completed on an empty queue");

  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift && ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("shift writes the entry it is reading");

endmodule
